@@ rtl/mass_pkg.sv @@
// ----------------------------------------------------------------------------
// mass_pkg
// Types and constants shared by the motor axis state supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package mass_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_CL   = 3'd1,
    PH_CL        = 3'd2,
    PH_WAIT_IDLE = 3'd3,
    PH_ERROR     = 3'd4
  } phase_t;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_REQ_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RECOVERY    = 2'd1;
  localparam logic [1:0] REG_IDLE_CODE   = 2'd2;
  localparam logic [1:0] REG_CL_CODE     = 2'd3;

  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [31:0] REQ_TIMEOUT_RST = 32'd2000;
  localparam logic [31:0] RECOVERY_RST    = 32'd1000;
  localparam logic [7:0]  IDLE_CODE_RST   = 8'd1;
  localparam logic [7:0]  CL_CODE_RST     = 8'd8;

  typedef struct packed {
    logic [31:0] req_timeout;
    logic [31:0] recovery;
    logic [7:0]  idle_code;
    logic [7:0]  cl_code;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [7:0] cmd_code;
    phase_t     nxt_phase;
    logic       rt_load;
    logic       fault_inc;
  } step_t;

endpackage

`default_nettype wire

@@ rtl/mass_in_if.sv @@
// ----------------------------------------------------------------------------
// mass_in_if
// Input channel: update tick or force-idle request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mass_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        driving;
  logic [31:0] now_ms;
  logic [7:0]  hb_axis_state;
  logic [31:0] hb_axis_error;

  modport source (output valid, func, driving, now_ms, hb_axis_state, hb_axis_error,
                  input ready);
  modport sink   (input valid, func, driving, now_ms, hb_axis_state, hb_axis_error,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/mass_out_if.sv @@
// ----------------------------------------------------------------------------
// mass_out_if
// Result channel: axis command, state and fault count.
// ----------------------------------------------------------------------------
`default_nettype none

interface mass_out_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic [7:0]  cmd_axis_state;
  logic [2:0]  fsm_state;
  logic        in_closed_loop;
  logic [31:0] fault_count;

  modport source (output valid, cmd_valid, cmd_axis_state, fsm_state, in_closed_loop,
                  fault_count, input ready);
  modport sink   (input valid, cmd_valid, cmd_axis_state, fsm_state, in_closed_loop,
                  fault_count, output ready);
endinterface

`default_nettype wire

@@ rtl/mass_regs.sv @@
// ----------------------------------------------------------------------------
// mass_regs
// APB register file: timeout, recovery interval and the two axis codes.
// ----------------------------------------------------------------------------
`default_nettype none

module mass_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mass_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  output mass_pkg::cfg_t                          cfg
);

  mass_pkg::cfg_t cfg_r;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.req_timeout <= mass_pkg::REQ_TIMEOUT_RST;
      cfg_r.recovery    <= mass_pkg::RECOVERY_RST;
      cfg_r.idle_code   <= mass_pkg::IDLE_CODE_RST;
      cfg_r.cl_code     <= mass_pkg::CL_CODE_RST;
    end else if (wr_en) begin
      case (idx)
        mass_pkg::REG_REQ_TIMEOUT: cfg_r.req_timeout <= pwdata;
        mass_pkg::REG_RECOVERY:    cfg_r.recovery    <= pwdata;
        mass_pkg::REG_IDLE_CODE:   cfg_r.idle_code   <= pwdata[7:0];
        mass_pkg::REG_CL_CODE:     cfg_r.cl_code     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mass_pkg::REG_REQ_TIMEOUT: prdata = cfg_r.req_timeout;
      mass_pkg::REG_RECOVERY:    prdata = cfg_r.recovery;
      mass_pkg::REG_IDLE_CODE:   prdata = {24'd0, cfg_r.idle_code};
      mass_pkg::REG_CL_CODE:     prdata = {24'd0, cfg_r.cl_code};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mass_step.sv @@
// ----------------------------------------------------------------------------
// mass_step
// One supervisor step: next phase, command and fault bump for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module mass_step #(
  parameter int unsigned TICK_BITS = 32
) (
  input  wire mass_pkg::cfg_t         cfg,
  input  wire mass_pkg::phase_t       phase,
  input  wire logic [TICK_BITS-1:0]   req_time,
  input  wire logic                   func,
  input  wire logic                   driving,
  input  wire logic [TICK_BITS-1:0]   now_t,
  input  wire logic [7:0]             hb_axis_state,
  input  wire logic [31:0]            hb_axis_error,
  output mass_pkg::step_t             step
);

  localparam int unsigned EW = (TICK_BITS > 32) ? TICK_BITS : 32;

  logic [TICK_BITS-1:0] elapsed;
  logic                 req_expired;
  logic                 rec_expired;
  logic                 hb_idle;
  logic                 hb_fault;

  assign elapsed     = now_t - req_time;
  assign req_expired = EW'(elapsed) > EW'(cfg.req_timeout);
  assign rec_expired = EW'(elapsed) > EW'(cfg.recovery);
  assign hb_idle     = hb_axis_state == cfg.idle_code;
  assign hb_fault    = hb_axis_error != 32'd0;

  always_comb begin
    step.cmd_valid = 1'b0;
    step.cmd_code  = 8'd0;
    step.nxt_phase = phase;
    step.rt_load   = 1'b0;
    step.fault_inc = 1'b0;
    if (func) begin
      step.cmd_valid = 1'b1;
      step.cmd_code  = cfg.idle_code;
      step.rt_load   = 1'b1;
      step.nxt_phase = mass_pkg::PH_WAIT_IDLE;
    end else begin
      case (phase)
        mass_pkg::PH_IDLE: begin
          if (driving) begin
            step.cmd_valid = 1'b1;
            step.cmd_code  = cfg.cl_code;
            step.rt_load   = 1'b1;
            step.nxt_phase = mass_pkg::PH_WAIT_CL;
          end
        end
        mass_pkg::PH_WAIT_CL: begin
          if (!driving) begin
            step.cmd_valid = 1'b1;
            step.cmd_code  = cfg.idle_code;
            step.rt_load   = 1'b1;
            step.nxt_phase = mass_pkg::PH_WAIT_IDLE;
          end else if (hb_axis_state == cfg.cl_code) begin
            step.nxt_phase = mass_pkg::PH_CL;
          end else if (req_expired) begin
            // timeout drops straight to idle, request time left as is
            step.fault_inc = 1'b1;
            step.cmd_valid = 1'b1;
            step.cmd_code  = cfg.idle_code;
            step.nxt_phase = mass_pkg::PH_IDLE;
          end
        end
        mass_pkg::PH_CL: begin
          if (hb_fault || !driving) begin
            step.fault_inc = hb_fault;
            step.cmd_valid = 1'b1;
            step.cmd_code  = cfg.idle_code;
            step.rt_load   = 1'b1;
            step.nxt_phase = mass_pkg::PH_WAIT_IDLE;
          end
        end
        mass_pkg::PH_WAIT_IDLE: begin
          if (hb_idle) begin
            step.nxt_phase = mass_pkg::PH_IDLE;
          end else if (req_expired) begin
            step.fault_inc = 1'b1;
            step.nxt_phase = mass_pkg::PH_ERROR;
          end
        end
        mass_pkg::PH_ERROR: begin
          if (rec_expired) begin
            step.cmd_valid = 1'b1;
            step.cmd_code  = cfg.idle_code;
            step.rt_load   = 1'b1;
            if (hb_idle && !hb_fault) begin
              step.nxt_phase = mass_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          step.nxt_phase = mass_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/motor_axis_state_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// motor_axis_state_supervisor_top
// Axis state supervisor: input register, one-step state update, result register.
// ----------------------------------------------------------------------------
// Throughput: 1 item per cycle; the input register takes one more beat while
//   a result waits on a stalled output, then the input stalls.
// Reset (rst_n low, synchronous): phase idle, request time and fault count
//   zero, registers back to their defaults, both stages empty.
`default_nettype none

module motor_axis_state_supervisor_top #(
  parameter int unsigned TICK_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  mass_in_if.sink                               in_ch,
  mass_out_if.source                            out_ch,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [mass_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]                      cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned EW = (TICK_BITS > 32) ? TICK_BITS : 32;

  mass_pkg::cfg_t   cfg;
  mass_pkg::step_t  step;

  // input stage
  logic                 s1_valid_r;
  logic                 s1_func_r;
  logic                 s1_driving_r;
  logic [TICK_BITS-1:0] s1_now_r;
  logic [7:0]           s1_hbs_r;
  logic [31:0]          s1_hbe_r;
  logic [EW-1:0]        now_ext;

  // supervisor state
  mass_pkg::phase_t     phase_r;
  logic [TICK_BITS-1:0] req_time_r;
  logic [31:0]          faults_r;
  logic [31:0]          faults_nxt;

  // result stage
  logic                 out_valid_r;
  logic                 out_cmd_r;
  logic [7:0]           out_code_r;
  logic [2:0]           out_state_r;
  logic                 out_cl_r;
  logic [31:0]          out_faults_r;

  logic adv;
  logic s1_fire;
  logic in_fire;

  mass_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mass_step #(.TICK_BITS(TICK_BITS)) u_step (
    .cfg           (cfg),
    .phase         (phase_r),
    .req_time      (req_time_r),
    .func          (s1_func_r),
    .driving       (s1_driving_r),
    .now_t         (s1_now_r),
    .hb_axis_state (s1_hbs_r),
    .hb_axis_error (s1_hbe_r),
    .step          (step)
  );

  assign adv         = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign now_ext     = EW'(in_ch.now_ms);
  assign faults_nxt  = faults_r + {31'd0, step.fault_inc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r    <= in_ch.func;
      s1_driving_r <= in_ch.driving;
      s1_now_r     <= now_ext[TICK_BITS-1:0];
      s1_hbs_r     <= in_ch.hb_axis_state;
      s1_hbe_r     <= in_ch.hb_axis_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mass_pkg::PH_IDLE;
      req_time_r <= '0;
      faults_r   <= 32'd0;
    end else if (s1_fire) begin
      phase_r  <= step.nxt_phase;
      faults_r <= faults_nxt;
      if (step.rt_load) begin
        req_time_r <= s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_cmd_r    <= step.cmd_valid;
      out_code_r   <= step.cmd_code;
      out_state_r  <= step.nxt_phase;
      out_cl_r     <= step.nxt_phase == mass_pkg::PH_CL;
      out_faults_r <= faults_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cmd_valid      = out_cmd_r;
  assign out_ch.cmd_axis_state = out_code_r;
  assign out_ch.fsm_state      = out_state_r;
  assign out_ch.in_closed_loop = out_cl_r;
  assign out_ch.fault_count    = out_faults_r;

endmodule

`default_nettype wire
